@@ sv/mlqs_pkg.sv @@
package mlqs_pkg;

  localparam int unsigned LEVELS       = 8;
  localparam int unsigned LVL_BITS     = 3;
  localparam int unsigned PID_BITS     = 16;
  localparam int unsigned CFG_BITS     = 4;
  localparam int unsigned CAPACITY_DEF = 64;

  typedef enum logic [2:0] {
    REQ_ADD      = 3'd0,
    REQ_EXEC     = 3'd1,
    REQ_MOVE     = 3'd2,
    REQ_END_HEAD = 3'd3,
    REQ_END_PID  = 3'd4
  } req_code_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_NO_LEVEL  = 3'd1,
    ST_NOT_FOUND = 3'd2,
    ST_EMPTY     = 3'd3,
    ST_FULL      = 3'd4
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISP,
    S_ALLOC_RD,
    S_APPEND,
    S_SCAN,
    S_POP_RD,
    S_POP,
    S_WLVL,
    S_WTEST,
    S_WRD,
    S_WCHK,
    S_UNLINK,
    S_DONE
  } state_e;

  typedef struct packed {
    logic [2:0]          req_type;
    logic [PID_BITS-1:0] pid;
    logic [LVL_BITS-1:0] priority_req;
  } req_t;

  typedef struct packed {
    status_e             status;
    logic [PID_BITS-1:0] pid_out;
    logic [LVL_BITS-1:0] from_level;
    logic [LVL_BITS-1:0] to_level;
  } rsp_t;

endpackage

@@ sv/multilevel_queue_scheduler.sv @@
// Move / end pid walk each level's linked list over the slot memory
// (one registered read per visited entry).
// One transaction at a time in the engine; a 2-entry request
// queue and a result register decouple both sides.
// Reset: counts and pointers cleared, levels_in_use = 8; no clearing pass.
module multilevel_queue_scheduler #(
  parameter int unsigned CAPACITY = mlqs_pkg::CAPACITY_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          push,
  output logic                          full,
  input  mlqs_pkg::req_t                req_i,
  output logic                          empty,
  input  logic                          pop,
  output mlqs_pkg::rsp_t                rsp_o,
  input  logic                          cfg_we_i,
  input  logic [mlqs_pkg::CFG_BITS-1:0] cfg_wdata_i
);
  import mlqs_pkg::*;

  logic [CFG_BITS-1:0] levels_q;
  logic                req_valid, req_take, rsp_valid;
  req_t                req;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      levels_q <= CFG_BITS'(LEVELS);
    end else if (cfg_we_i) begin
      levels_q <= cfg_wdata_i;
    end
  end

  mlqs_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .req_i       (req_i),
    .full_o      (full),
    .req_valid_o (req_valid),
    .req_o       (req),
    .req_take_i  (req_take)
  );

  mlqs_back #(.CAPACITY(CAPACITY)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .levels_i    (levels_q),
    .req_valid_i (req_valid),
    .req_i       (req),
    .req_take_o  (req_take),
    .rsp_valid_o (rsp_valid),
    .rsp_o       (rsp_o),
    .rsp_pop_i   (pop)
  );

  assign empty = !rsp_valid;

endmodule

@@ sv/mlqs_front.sv @@
module mlqs_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  mlqs_pkg::req_t req_i,
  output logic          full_o,
  output logic          req_valid_o,
  output mlqs_pkg::req_t req_o,
  input  logic          req_take_i
);
  import mlqs_pkg::*;

  req_t       buf_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;
  logic       do_push, do_pop;

  assign full_o      = (cnt_q == 2'd2);
  assign req_valid_o = (cnt_q != 2'd0);
  assign req_o       = buf_q[rd_ptr_q];
  assign do_push     = push_i && !full_o;
  assign do_pop      = req_take_i && req_valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      buf_q[wr_ptr_q] <= req_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (do_pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      cnt_q <= cnt_q + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

endmodule

@@ sv/mlqs_back.sv @@
module mlqs_back #(
  parameter int unsigned CAPACITY = mlqs_pkg::CAPACITY_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [mlqs_pkg::CFG_BITS-1:0] levels_i,
  input  logic                          req_valid_i,
  input  mlqs_pkg::req_t                req_i,
  output logic                          req_take_o,
  output logic                          rsp_valid_o,
  output mlqs_pkg::rsp_t                rsp_o,
  input  logic                          rsp_pop_i
);
  import mlqs_pkg::*;

  localparam int unsigned CW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned NW = $clog2(CAPACITY + 1);
  localparam logic [NW-1:0] CAP_N = NW'(CAPACITY);

  logic [PID_BITS-1:0] pid_mem  [CAPACITY];
  logic [CW-1:0]       nxt_mem  [CAPACITY];
  logic [CW-1:0]       fstk_mem [CAPACITY];

  logic [CW-1:0]       head_q [LEVELS];
  logic [CW-1:0]       tail_q [LEVELS];
  logic [NW-1:0]       cnt_q  [LEVELS];

  state_e              state_q, state_d;
  req_t                cur_q;
  logic [LVL_BITS-1:0] lvl_q, from_q, to_q;
  logic [CW-1:0]       slot_q, prev_q;
  logic                hp_q;
  logic [NW-1:0]       k_q, fresh_q, fcnt_q;
  status_e             st_q;
  logic [PID_BITS-1:0] pout_q, pid_rd_q;
  logic [CW-1:0]       nxt_rd_q, fstk_rd_q;
  rsp_t                rsp_q;
  logic                rsp_valid_q;

  req_code_e           op;
  logic [CFG_BITS-1:0] n_eff;
  logic [LVL_BITS-1:0] last_lvl, pri, lvl_dn;
  logic                pri_bad, match, lvl_empty, done_fire;
  logic                nxt_we, pid_we, fstk_we;
  logic [CW-1:0]       nxt_wa, nxt_wd;

  assign op        = req_code_e'(cur_q.req_type);
  assign pri       = cur_q.priority_req;
  assign n_eff     = (levels_i == '0) ? CFG_BITS'(1) :
                     (levels_i > CFG_BITS'(LEVELS)) ? CFG_BITS'(LEVELS) : levels_i;
  assign last_lvl  = LVL_BITS'(n_eff - CFG_BITS'(1));
  assign pri_bad   = ({1'b0, pri} >= n_eff);
  assign match     = (pid_rd_q == cur_q.pid);
  assign lvl_empty = (cnt_q[lvl_q] == '0);
  assign lvl_dn    = (lvl_q != '0) ? lvl_q - 1'b1 : '0;
  assign done_fire = (state_q == S_DONE) && (!rsp_valid_q || rsp_pop_i);

  assign req_take_o  = (state_q == S_IDLE);
  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;

  always_comb begin
    nxt_we  = 1'b0;
    nxt_wa  = prev_q;
    nxt_wd  = nxt_rd_q;
    pid_we  = 1'b0;
    fstk_we = 1'b0;
    case (state_q)
      S_APPEND: begin
        nxt_we = !lvl_empty;
        nxt_wa = tail_q[lvl_q];
        nxt_wd = slot_q;
        pid_we = (op == REQ_ADD);
      end
      S_POP:    fstk_we = (op == REQ_END_HEAD);
      S_UNLINK: begin
        nxt_we  = hp_q;
        fstk_we = (op == REQ_END_PID);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (pid_we) begin
      pid_mem[slot_q] <= cur_q.pid;
    end
    if (nxt_we) begin
      nxt_mem[nxt_wa] <= nxt_wd;
    end
    if (fstk_we) begin
      fstk_mem[fcnt_q[CW-1:0]] <= slot_q;
    end
    pid_rd_q  <= pid_mem[slot_q];
    nxt_rd_q  <= nxt_mem[slot_q];
    fstk_rd_q <= fstk_mem[CW'(fcnt_q - NW'(1))];
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (req_valid_i) state_d = S_DISP;
      end
      S_DISP: begin
        case (op)
          REQ_ADD: begin
            if (pri_bad)               state_d = S_DONE;
            else if (fresh_q != CAP_N) state_d = S_APPEND;
            else if (fcnt_q != '0)     state_d = S_ALLOC_RD;
            else                       state_d = S_DONE;
          end
          REQ_EXEC, REQ_END_HEAD: state_d = S_SCAN;
          REQ_MOVE, REQ_END_PID:  state_d = S_WLVL;
          default:                state_d = S_DONE;
        endcase
      end
      S_ALLOC_RD: state_d = S_APPEND;
      S_APPEND:   state_d = S_DONE;
      S_SCAN: begin
        if (!lvl_empty)          state_d = S_POP_RD;
        else if (lvl_q == '0)    state_d = S_DONE;
      end
      S_POP_RD: state_d = S_POP;
      S_POP:    state_d = (op == REQ_EXEC) ? S_APPEND : S_DONE;
      S_WLVL:   state_d = S_WTEST;
      S_WTEST: begin
        if (k_q == cnt_q[lvl_q]) state_d = (lvl_q == last_lvl) ? S_DONE : S_WLVL;
        else                     state_d = S_WRD;
      end
      S_WRD:    state_d = S_WCHK;
      S_WCHK: begin
        if (!match)                         state_d = S_WTEST;
        else if (op == REQ_MOVE && pri_bad) state_d = S_DONE;
        else                                state_d = S_UNLINK;
      end
      S_UNLINK: state_d = (op == REQ_MOVE) ? S_APPEND : S_DONE;
      S_DONE: begin
        if (done_fire) state_d = S_IDLE;
      end
      default:  state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        if (req_valid_i) cur_q <= req_i;
      end
      S_DISP: begin
        from_q <= '0;
        case (op)
          REQ_ADD: begin
            pout_q <= cur_q.pid;
            if (pri_bad) begin
              st_q <= ST_NO_LEVEL;
              to_q <= '0;
            end else if (fresh_q != CAP_N) begin
              st_q   <= ST_OK;
              slot_q <= fresh_q[CW-1:0];
              lvl_q  <= pri;
              to_q   <= pri;
            end else if (fcnt_q != '0) begin
              st_q  <= ST_OK;
              lvl_q <= pri;
              to_q  <= pri;
            end else begin
              st_q <= ST_FULL;
              to_q <= '0;
            end
          end
          REQ_EXEC, REQ_END_HEAD: begin
            st_q   <= ST_OK;
            to_q   <= '0;
            lvl_q  <= last_lvl;
            pout_q <= '0;
          end
          REQ_MOVE, REQ_END_PID: begin
            st_q   <= ST_OK;
            to_q   <= '0;
            lvl_q  <= '0;
            pout_q <= cur_q.pid;
          end
          default: begin
            st_q   <= ST_OK;
            to_q   <= '0;
            pout_q <= '0;
          end
        endcase
      end
      S_ALLOC_RD: slot_q <= fstk_rd_q;
      S_APPEND: begin
        if (lvl_empty) head_q[lvl_q] <= slot_q;
        tail_q[lvl_q] <= slot_q;
      end
      S_SCAN: begin
        if (!lvl_empty) begin
          slot_q <= head_q[lvl_q];
          from_q <= lvl_q;
        end else if (lvl_q == '0) begin
          st_q <= ST_EMPTY;
        end else begin
          lvl_q <= lvl_q - 1'b1;
        end
      end
      S_POP: begin
        pout_q        <= pid_rd_q;
        head_q[lvl_q] <= nxt_rd_q;
        if (op == REQ_EXEC) begin
          lvl_q <= lvl_dn;
          to_q  <= lvl_dn;
        end
      end
      S_WLVL: begin
        slot_q <= head_q[lvl_q];
        k_q    <= '0;
        hp_q   <= 1'b0;
      end
      S_WTEST: begin
        if (k_q == cnt_q[lvl_q]) begin
          if (lvl_q == last_lvl) st_q <= ST_NOT_FOUND;
          else                   lvl_q <= lvl_q + 1'b1;
        end
      end
      S_WCHK: begin
        if (match) begin
          if (op == REQ_MOVE && pri_bad) st_q <= ST_NO_LEVEL;
          else                           from_q <= lvl_q;
        end else begin
          prev_q <= slot_q;
          hp_q   <= 1'b1;
          slot_q <= nxt_rd_q;
          k_q    <= k_q + NW'(1);
        end
      end
      S_UNLINK: begin
        if (!hp_q) begin
          head_q[lvl_q] <= nxt_rd_q;
        end else if (tail_q[lvl_q] == slot_q) begin
          tail_q[lvl_q] <= prev_q;
        end
        if (op == REQ_MOVE) begin
          lvl_q <= pri;
          to_q  <= pri;
        end
      end
      S_DONE: begin
        if (done_fire) rsp_q <= '{status: st_q, pid_out: pout_q,
                                  from_level: from_q, to_level: to_q};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      fresh_q     <= '0;
      fcnt_q      <= '0;
      rsp_valid_q <= 1'b0;
      for (int i = 0; i < LEVELS; i++) begin
        cnt_q[i] <= '0;
      end
    end else begin
      state_q     <= state_d;
      rsp_valid_q <= (rsp_valid_q && !rsp_pop_i) || done_fire;
      case (state_q)
        S_DISP: begin
          if (op == REQ_ADD && !pri_bad) begin
            if (fresh_q != CAP_N)  fresh_q <= fresh_q + NW'(1);
            else if (fcnt_q != '0) fcnt_q  <= fcnt_q - NW'(1);
          end
        end
        S_APPEND: cnt_q[lvl_q] <= cnt_q[lvl_q] + NW'(1);
        S_POP: begin
          cnt_q[lvl_q] <= cnt_q[lvl_q] - NW'(1);
          if (op == REQ_END_HEAD) fcnt_q <= fcnt_q + NW'(1);
        end
        S_UNLINK: begin
          cnt_q[lvl_q] <= cnt_q[lvl_q] - NW'(1);
          if (op == REQ_END_PID) fcnt_q <= fcnt_q + NW'(1);
        end
        default: ;
      endcase
    end
  end

  a_free_le_fresh: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fcnt_q <= fresh_q) else $error("free stack deeper than allocated slots");

  a_fresh_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fresh_q <= CAP_N) else $error("fresh slot counter overflow");

  a_append_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_APPEND |-> cnt_q[lvl_q] != CAP_N) else $error("level count overflow");

  a_done_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_fire |=> rsp_valid_q && state_q == S_IDLE) else $error("result lost");

endmodule
